>>> rtl/eth_arp_ipv4_rx_classifier_unit_macros.svh
// Assertion helpers shared by the classifier RTL.
`ifndef ETH_ARP_IPV4_RX_CLASSIFIER_UNIT_MACROS_SVH
`define ETH_ARP_IPV4_RX_CLASSIFIER_UNIT_MACROS_SVH

// Checks a property on every rising edge of clk outside of reset.
`define EARC_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("classifier assertion failed");

// Checks that a condition never holds.
`define EARC_NEVER(label, cond) \
	`EARC_ASSERT(label, !(cond))

`endif

>>> rtl/earc_pkg.sv
package earc_pkg;

	localparam int COUNT_BITS = 11;

	typedef logic [COUNT_BITS-1:0] count_t;

	localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

	// Byte offsets within the frame.
	localparam count_t POS_KIND_HI   = count_t'(12);
	localparam count_t POS_KIND_LO   = count_t'(13);
	localparam count_t POS_IHL       = count_t'(14);
	localparam count_t POS_OP_HI     = count_t'(20);
	localparam count_t POS_OP_LO     = count_t'(21);
	localparam count_t POS_SHA_FIRST = count_t'(22);
	localparam count_t POS_PROTO     = count_t'(23);
	localparam count_t POS_SHA_LAST  = count_t'(27);
	localparam count_t POS_SPA_FIRST = count_t'(28);
	localparam count_t POS_DST_FIRST = count_t'(30);
	localparam count_t POS_SPA_LAST  = count_t'(31);
	localparam count_t POS_DST_LAST  = count_t'(33);
	localparam count_t POS_TPA_FIRST = count_t'(38);
	localparam count_t POS_TPA_LAST  = count_t'(41);

	// Minimum lengths, written as the offset of the last byte.
	localparam count_t LAST_ETH_MIN  = count_t'(13);
	localparam count_t LAST_IPV4_MIN = count_t'(33);
	localparam count_t LAST_ARP_MIN  = count_t'(41);
	localparam count_t ICMP_HDR_SPAN = count_t'(8);

	localparam logic [15:0] KIND_ARP   = 16'h0806;
	localparam logic [15:0] KIND_IPV4  = 16'h0800;
	localparam logic [15:0] ARP_REPLY  = 16'd2;
	localparam logic [7:0]  PROTO_ICMP = 8'd1;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;
	localparam logic [7:0]  ICMP_ECHO_REPLY = 8'd0;
	localparam logic [3:0]  IHL_MASK   = 4'hf;

	localparam logic [1:0] VERDICT_IGNORED = 2'd0;
	localparam logic [1:0] VERDICT_LEARNED = 2'd1;
	localparam logic [1:0] VERDICT_ICMP    = 2'd2;
	localparam logic [1:0] VERDICT_UDP     = 2'd3;

	localparam logic [1:0] REG_LOCAL   = 2'd0;
	localparam logic [1:0] REG_GATEWAY = 2'd1;

	localparam logic [31:0] LOCAL_RESET   = 32'h0a00_020f;
	localparam logic [31:0] GATEWAY_RESET = 32'h0a00_0202;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} rx_item_t;

	typedef struct packed {
		logic [1:0]  verdict;
		logic [47:0] learned_mac;
		logic        learned_valid;
	} rx_result_t;

	// Octet k of an address, octet 0 being the most significant.
	function automatic logic [7:0] addr_octet(input logic [31:0] addr, input logic [1:0] k);
		logic [7:0] o;
		unique case (k)
			2'd0: o = addr[31:24];
			2'd1: o = addr[23:16];
			2'd2: o = addr[15:8];
			default: o = addr[7:0];
		endcase
		return o;
	endfunction

endpackage

>>> rtl/earc_in_reg.sv
module earc_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          frame_byte,
	input  logic                last_byte,
	input  logic                take,
	output logic                valid_s1,
	output earc_pkg::rx_item_t  item_s1
);
	import earc_pkg::*;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.frame_byte <= frame_byte;
			item_s1.last_byte  <= last_byte;
		end
	end

endmodule

>>> rtl/earc_parse.sv
module earc_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  earc_pkg::rx_item_t   item,
	input  logic [31:0]          local_addr,
	input  logic [31:0]          gateway_addr,
	output earc_pkg::rx_result_t result
);
	import earc_pkg::*;

	count_t      byte_count_q;
	logic [15:0] ether_kind_q, ether_kind_n;
	logic [15:0] arp_op_q, arp_op_n;
	logic [47:0] sender_mac_q, sender_mac_n;
	logic        sender_gw_q, sender_gw_n;
	logic        target_local_q, target_local_n;
	logic        dest_local_q, dest_local_n;
	logic [5:0]  header_bytes_q, header_bytes_n;
	logic [7:0]  protocol_q, protocol_n;
	logic [7:0]  icmp_kind_q, icmp_kind_n;
	logic [47:0] gateway_mac_q;
	logic        gateway_known_q;

	count_t      pos;
	logic [7:0]  b;
	logic        arp_hit;
	count_t      hdr_last, icmp_last;

	assign pos = byte_count_q;
	assign b   = item.frame_byte;

	always_comb begin
		ether_kind_n = ether_kind_q;
		if (pos == POS_KIND_HI || pos == POS_KIND_LO) begin
			ether_kind_n = {ether_kind_q[7:0], b};
		end
		arp_op_n = arp_op_q;
		if (pos == POS_OP_HI || pos == POS_OP_LO) begin
			arp_op_n = {arp_op_q[7:0], b};
		end
		sender_mac_n = sender_mac_q;
		if (pos >= POS_SHA_FIRST && pos <= POS_SHA_LAST) begin
			sender_mac_n = {sender_mac_q[39:0], b};
		end
		// The address windows start on 28, 30 and 38, so the octet index follows
		// from the low two bits of the offset.
		sender_gw_n = sender_gw_q;
		if (pos >= POS_SPA_FIRST && pos <= POS_SPA_LAST &&
			b != addr_octet(gateway_addr, pos[1:0])) begin
			sender_gw_n = 1'b0;
		end
		target_local_n = target_local_q;
		if (pos >= POS_TPA_FIRST && pos <= POS_TPA_LAST &&
			b != addr_octet(local_addr, pos[1:0] - 2'd2)) begin
			target_local_n = 1'b0;
		end
		dest_local_n = dest_local_q;
		if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST &&
			b != addr_octet(local_addr, pos[1:0] - 2'd2)) begin
			dest_local_n = 1'b0;
		end
		header_bytes_n = header_bytes_q;
		if (pos == POS_IHL) begin
			header_bytes_n = {b[3:0] & IHL_MASK, 2'b00};
		end
		protocol_n = protocol_q;
		if (pos == POS_PROTO) begin
			protocol_n = b;
		end
		icmp_kind_n = icmp_kind_q;
		if (pos == POS_IHL + count_t'(header_bytes_n)) begin
			icmp_kind_n = b;
		end
	end

	assign hdr_last  = LAST_ETH_MIN + count_t'(header_bytes_n);
	assign icmp_last = hdr_last + ICMP_HDR_SPAN;

	assign arp_hit = pos >= LAST_ARP_MIN && ether_kind_n == KIND_ARP &&
		arp_op_n == ARP_REPLY && sender_gw_n && target_local_n;

	always_comb begin
		result.verdict = VERDICT_IGNORED;
		priority if (pos < LAST_ETH_MIN) begin
			result.verdict = VERDICT_IGNORED;
		end else if (ether_kind_n == KIND_ARP && pos >= LAST_ARP_MIN) begin
			if (arp_hit) begin
				result.verdict = VERDICT_LEARNED;
			end
		end else if (ether_kind_n == KIND_IPV4 && pos >= LAST_IPV4_MIN &&
			dest_local_n && pos >= hdr_last) begin
			if (protocol_n == PROTO_ICMP) begin
				if (pos >= icmp_last && icmp_kind_n == ICMP_ECHO_REPLY) begin
					result.verdict = VERDICT_ICMP;
				end
			end else if (protocol_n == PROTO_UDP) begin
				result.verdict = VERDICT_UDP;
			end
		end else begin
			result.verdict = VERDICT_IGNORED;
		end
		result.learned_mac   = arp_hit ? sender_mac_n : gateway_mac_q;
		result.learned_valid = arp_hit || gateway_known_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gateway_mac_q   <= '0;
			gateway_known_q <= 1'b0;
		end else if (take && item.last_byte && arp_hit) begin
			gateway_mac_q   <= sender_mac_n;
			gateway_known_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			ether_kind_q   <= '0;
			arp_op_q       <= '0;
			sender_mac_q   <= '0;
			sender_gw_q    <= 1'b1;
			target_local_q <= 1'b1;
			dest_local_q   <= 1'b1;
			header_bytes_q <= '0;
			protocol_q     <= '0;
			icmp_kind_q    <= '1;
		end else if (take) begin
			if (item.last_byte) begin
				byte_count_q   <= '0;
				ether_kind_q   <= '0;
				arp_op_q       <= '0;
				sender_mac_q   <= '0;
				sender_gw_q    <= 1'b1;
				target_local_q <= 1'b1;
				dest_local_q   <= 1'b1;
				header_bytes_q <= '0;
				protocol_q     <= '0;
				icmp_kind_q    <= '1;
			end else begin
				if (byte_count_q != COUNT_MAX) begin
					byte_count_q <= byte_count_q + count_t'(1);
				end
				ether_kind_q   <= ether_kind_n;
				arp_op_q       <= arp_op_n;
				sender_mac_q   <= sender_mac_n;
				sender_gw_q    <= sender_gw_n;
				target_local_q <= target_local_n;
				dest_local_q   <= dest_local_n;
				header_bytes_q <= header_bytes_n;
				protocol_q     <= protocol_n;
				icmp_kind_q    <= icmp_kind_n;
			end
		end
	end

endmodule

>>> rtl/eth_arp_ipv4_rx_classifier_unit.sv
// Channel   Handshake                Payload
// input     in_valid / in_ready      frame_byte, last_byte
// output    out_valid / out_ready    verdict, learned_mac, learned_valid
// config    cfg_we (no wait)         cfg_index, cfg_data
//
// One byte per cycle sustained unless a final byte waits on a held verdict. A byte is parsed
// in the cycle after its transfer into the input register, and a final byte's verdict is
// loaded into the output register when that byte moves on, which raises out_valid.
// Reset clears the frame state, the learned gateway MAC and both addresses to
// their defaults. A held verdict stalls only a final byte in the input register, and
// the input behind it; other bytes move on regardless of the output.
`include "eth_arp_ipv4_rx_classifier_unit_macros.svh"

module eth_arp_ipv4_rx_classifier_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  frame_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  verdict,
	output logic [47:0] learned_mac,
	output logic        learned_valid,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import earc_pkg::*;

	logic       valid_s1;
	rx_item_t   item_s1;
	rx_result_t result;
	logic       take;
	logic [31:0] local_addr_q, gateway_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_addr_q   <= LOCAL_RESET;
			gateway_addr_q <= GATEWAY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOCAL:   local_addr_q   <= cfg_data;
				REG_GATEWAY: gateway_addr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A final byte moves on only when the output register is free this cycle.
	assign take = valid_s1 && (!item_s1.last_byte || !out_valid || out_ready);

	earc_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.frame_byte (frame_byte),
		.last_byte  (last_byte),
		.take       (take),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	earc_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.item         (item_s1),
		.local_addr   (local_addr_q),
		.gateway_addr (gateway_addr_q),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take && item_s1.last_byte) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item_s1.last_byte) begin
			verdict       <= result.verdict;
			learned_mac   <= result.learned_mac;
			learned_valid <= result.learned_valid;
		end
	end

	`EARC_NEVER(a_learned_sets_valid, out_valid && verdict == VERDICT_LEARNED && !learned_valid)
	`EARC_ASSERT(a_known_sticks, (out_valid && learned_valid) |=> (!out_valid || learned_valid))
	`EARC_NEVER(a_no_overwrite, take && item_s1.last_byte && out_valid && !out_ready)

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import earc_pkg::*;

	localparam int LIMIT_CYCLES = 300000;
	localparam int DRAIN_CYCLES = 6;
	localparam int MAX_REPORTS  = 10;

	localparam logic [1:0]  REG_SPARE_A       = 2'd2;
	localparam logic [1:0]  REG_SPARE_B       = 2'd3;
	localparam logic [15:0] ARP_REQUEST       = 16'd1;
	localparam logic [7:0]  PROTO_TCP         = 8'd6;
	localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'd8;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  frame_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  verdict;
	logic [47:0] learned_mac;
	logic        learned_valid;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	eth_arp_ipv4_rx_classifier_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.frame_byte   (frame_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.verdict      (verdict),
		.learned_mac  (learned_mac),
		.learned_valid(learned_valid),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Addresses as the block holds them.
	logic [31:0] cfg_local;
	logic [31:0] cfg_gateway;

	// Parser state of the frame in progress, plus the learned gateway.
	count_t      fr_count;
	logic [15:0] fr_kind;
	logic [15:0] fr_op;
	logic [47:0] fr_sha;
	logic        fr_spa_ok;
	logic        fr_tpa_ok;
	logic        fr_dst_ok;
	logic [5:0]  fr_hdr;
	logic [7:0]  fr_proto;
	logic [7:0]  fr_icmp;
	logic [47:0] gw_mac;
	logic        gw_known;

	rx_result_t  verdict_q[$];
	rx_result_t  head;
	logic [7:0]  pkt[$];

	int  fail_count;
	int  hold_len;
	int  cycle_count;
	bit  idle_on;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	function automatic logic [7:0] addr_byte(input logic [31:0] a, input int k);
		return a[8*(3-k) +: 8];
	endfunction

	function automatic void clear_frame();
		fr_count  = '0;
		fr_kind   = '0;
		fr_op     = '0;
		fr_sha    = '0;
		fr_spa_ok = 1'b1;
		fr_tpa_ok = 1'b1;
		fr_dst_ok = 1'b1;
		fr_hdr    = '0;
		fr_proto  = '0;
		fr_icmp   = 8'hff;
	endfunction

	// Advances the parser by one accepted byte and queues a verdict on a last byte.
	function automatic void classify_byte(input logic [7:0] b, input logic fin);
		int         pos;
		logic [1:0] v;
		pos = int'(fr_count);
		if (pos == POS_KIND_HI || pos == POS_KIND_LO)
			fr_kind = {fr_kind[7:0], b};
		if (pos == POS_OP_HI || pos == POS_OP_LO)
			fr_op = {fr_op[7:0], b};
		if (pos >= POS_SHA_FIRST && pos <= POS_SHA_LAST)
			fr_sha = {fr_sha[39:0], b};
		if (pos >= POS_SPA_FIRST && pos <= POS_SPA_LAST
				&& b != addr_byte(cfg_gateway, pos - POS_SPA_FIRST))
			fr_spa_ok = 1'b0;
		if (pos >= POS_TPA_FIRST && pos <= POS_TPA_LAST
				&& b != addr_byte(cfg_local, pos - POS_TPA_FIRST))
			fr_tpa_ok = 1'b0;
		if (pos == POS_IHL)
			fr_hdr = {b[3:0] & IHL_MASK, 2'b00};
		if (pos == POS_PROTO)
			fr_proto = b;
		if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST
				&& b != addr_byte(cfg_local, pos - POS_DST_FIRST))
			fr_dst_ok = 1'b0;
		if (pos == int'(POS_IHL) + int'(fr_hdr))
			fr_icmp = b;
		if (fr_count != COUNT_MAX)
			fr_count = fr_count + 1'b1;
		if (!fin)
			return;
		v = VERDICT_IGNORED;
		if (pos >= LAST_ETH_MIN) begin
			if (fr_kind == KIND_ARP && pos >= LAST_ARP_MIN) begin
				if (fr_op == ARP_REPLY && fr_spa_ok && fr_tpa_ok) begin
					gw_mac   = fr_sha;
					gw_known = 1'b1;
					v = VERDICT_LEARNED;
				end
			end else if (fr_kind == KIND_IPV4 && pos >= LAST_IPV4_MIN && fr_dst_ok
					&& pos + 1 >= int'(POS_IHL) + int'(fr_hdr)) begin
				if (fr_proto == PROTO_ICMP) begin
					if (pos + 1 >= int'(POS_IHL) + int'(fr_hdr) + int'(ICMP_HDR_SPAN)
							&& fr_icmp == ICMP_ECHO_REPLY)
						v = VERDICT_ICMP;
				end else if (fr_proto == PROTO_UDP) begin
					v = VERDICT_UDP;
				end
			end
		end
		verdict_q.push_back('{verdict: v, learned_mac: gw_mac, learned_valid: gw_known});
		clear_frame();
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected verdict %0d mac %h valid %0b",
						verdict, learned_mac, learned_valid);
			end else begin
				head = verdict_q.pop_front();
				if (verdict !== head.verdict || learned_mac !== head.learned_mac
						|| learned_valid !== head.learned_valid) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("mismatch: expected verdict %0d mac %h valid %0b, got verdict %0d mac %h valid %0b",
							head.verdict, head.learned_mac, head.learned_valid,
							verdict, learned_mac, learned_valid);
				end
			end
		end
	end

	// Result side: random stalls, plus a long hold-off when one is requested.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_len != 0) begin
				out_ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		frame_byte <= b;
		last_byte  <= fin;
		do @(posedge clk); while (!in_ready);
		classify_byte(b, fin);
	endtask

	task automatic send_frame();
		for (int i = 0; i < pkt.size(); i++)
			send_byte(pkt[i], i == pkt.size() - 1);
	endtask

	// Lets every pending verdict drain, then waits out the drain time for a frame in flight.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_LOCAL)
			cfg_local = val;
		else if (idx == REG_GATEWAY)
			cfg_gateway = val;
		@(posedge clk);
	endtask

	function automatic void fill_random(input int n);
		pkt.delete();
		repeat (n) pkt.push_back(8'($urandom));
	endfunction

	// Writes only inside the frame, so a short frame simply loses the field.
	function automatic void put(input int p, input logic [7:0] v);
		if (p < pkt.size())
			pkt[p] = v;
	endfunction

	function automatic void put16(input int p, input logic [15:0] v);
		put(p, v[15:8]);
		put(p + 1, v[7:0]);
	endfunction

	function automatic void put32(input int p, input logic [31:0] v);
		for (int k = 0; k < 4; k++)
			put(p + k, addr_byte(v, k));
	endfunction

	function automatic void make_arp(input int n, input logic [15:0] op,
			input logic [31:0] spa, input logic [31:0] tpa, input logic [47:0] sha);
		fill_random(n);
		put16(POS_KIND_HI, KIND_ARP);
		put16(14, 16'h0001);
		put16(16, KIND_IPV4);
		put(18, 8'd6);
		put(19, 8'd4);
		put16(POS_OP_HI, op);
		for (int k = 0; k < 6; k++)
			put(POS_SHA_FIRST + k, sha[8*(5-k) +: 8]);
		put32(POS_SPA_FIRST, spa);
		put32(POS_TPA_FIRST, tpa);
	endfunction

	// The ICMP type goes in last, so a tiny header length lets it land on header bytes.
	function automatic void make_ipv4(input int n, input logic [3:0] ihl,
			input logic [7:0] proto, input logic [31:0] dst, input logic [7:0] icmp_type);
		fill_random(n);
		put16(POS_KIND_HI, KIND_IPV4);
		put(POS_IHL, {4'h4, ihl});
		put(POS_PROTO, proto);
		put32(POS_DST_FIRST, dst);
		put(POS_IHL + 4 * int'(ihl), icmp_type);
	endfunction

	function automatic logic [31:0] near_miss(input logic [31:0] a);
		return a ^ (32'h1 << $urandom_range(0, 31));
	endfunction

	function automatic void make_random_frame();
		int          r;
		int          n;
		int          hdr;
		int          idx;
		logic [3:0]  ihl;
		logic [7:0]  proto;
		logic [7:0]  icmp_type;
		logic [15:0] op;
		logic [31:0] spa;
		logic [31:0] tpa;
		logic [31:0] dst;
		logic [47:0] sha;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			op  = ($urandom_range(0, 5) == 0) ? 16'($urandom) : ARP_REPLY;
			spa = ($urandom_range(0, 5) == 0) ? near_miss(cfg_gateway) : cfg_gateway;
			tpa = ($urandom_range(0, 5) == 0) ? near_miss(cfg_local) : cfg_local;
			case ($urandom_range(0, 5))
				0: sha = '0;
				1: sha = '1;
				default: sha = {16'($urandom), 32'($urandom)};
			endcase
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 41) : $urandom_range(42, 64);
			make_arp(n, op, spa, tpa, sha);
		end else if (r < 80) begin
			ihl = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 4))
				: 4'($urandom_range(5, 15));
			case ($urandom_range(0, 9))
				0, 1, 2, 3: proto = PROTO_ICMP;
				4, 5, 6, 7: proto = PROTO_UDP;
				default: proto = 8'($urandom);
			endcase
			dst = ($urandom_range(0, 5) == 0) ? near_miss(cfg_local) : cfg_local;
			icmp_type = ($urandom_range(0, 3) == 0) ? 8'($urandom) : ICMP_ECHO_REPLY;
			hdr = 14 + 4 * int'(ihl);
			if ($urandom_range(0, 5) == 0)
				n = $urandom_range(14, hdr + 8);
			else
				n = $urandom_range((hdr + 8 > 34) ? hdr + 8 : 34, hdr + 30);
			make_ipv4(n, ihl, proto, dst, icmp_type);
		end else begin
			fill_random($urandom_range(1, 70));
			case ($urandom_range(0, 2))
				0: put16(POS_KIND_HI, KIND_ARP);
				1: put16(POS_KIND_HI, KIND_IPV4);
				default: ;
			endcase
		end
		if ($urandom_range(0, 7) == 0) begin
			idx = $urandom_range(0, pkt.size() - 1);
			pkt[idx] = pkt[idx] ^ 8'(1 << $urandom_range(0, 7));
		end
	endfunction

	task automatic random_config();
		logic [31:0] loc;
		logic [31:0] gw;
		wait_idle();
		case ($urandom_range(0, 3))
			0: begin loc = '0; gw = '1; end
			1: begin loc = '1; gw = '0; end
			default: begin loc = $urandom; gw = $urandom; end
		endcase
		write_reg(REG_LOCAL, loc);
		write_reg(REG_GATEWAY, gw);
		if ($urandom_range(0, 1) == 0)
			write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B, $urandom);
	endtask

	task automatic test_arp_replies();
		make_arp(42, ARP_REPLY, cfg_gateway, cfg_local, 48'h0200_0000_0001);
		send_frame();
		make_arp(60, ARP_REQUEST, cfg_gateway, cfg_local, 48'h0200_0000_0002);
		send_frame();
		make_arp(42, ARP_REPLY, cfg_gateway ^ 32'h1, cfg_local, 48'h0200_0000_0003);
		send_frame();
		make_arp(50, ARP_REPLY, cfg_gateway, cfg_local ^ 32'h8000_0000, '1);
		send_frame();
		// One byte short of a full ARP body.
		make_arp(41, ARP_REPLY, cfg_gateway, cfg_local, '1);
		send_frame();
		make_arp(42, ARP_REPLY, cfg_gateway, cfg_local, '1);
		send_frame();
		make_arp(43, ARP_REPLY, cfg_gateway, cfg_local, '0);
		send_frame();
	endtask

	task automatic test_ipv4_traffic();
		make_ipv4(34, 4'd5, PROTO_UDP, cfg_local, 8'h00);
		send_frame();
		make_ipv4(33, 4'd5, PROTO_UDP, cfg_local, 8'h00);
		send_frame();
		make_ipv4(40, 4'd5, PROTO_UDP, cfg_local ^ 32'h1, 8'h00);
		send_frame();
		make_ipv4(42, 4'd5, PROTO_ICMP, cfg_local, ICMP_ECHO_REPLY);
		send_frame();
		make_ipv4(41, 4'd5, PROTO_ICMP, cfg_local, ICMP_ECHO_REPLY);
		send_frame();
		make_ipv4(60, 4'd5, PROTO_ICMP, cfg_local, ICMP_ECHO_REQUEST);
		send_frame();
		make_ipv4(82, 4'd15, PROTO_ICMP, cfg_local, ICMP_ECHO_REPLY);
		send_frame();
		// Frame ends before the full header that the length field claims.
		make_ipv4(60, 4'd15, PROTO_UDP, cfg_local, 8'h00);
		send_frame();
		// Header length zero puts the ICMP type on the length byte itself.
		make_ipv4(40, 4'd0, PROTO_ICMP, cfg_local, ICMP_ECHO_REPLY);
		send_frame();
		make_ipv4(40, 4'd3, PROTO_ICMP, cfg_local, ICMP_ECHO_REPLY);
		send_frame();
		make_ipv4(50, 4'd5, PROTO_TCP, cfg_local, 8'h00);
		send_frame();
		fill_random(1);
		send_frame();
		fill_random(13);
		put16(POS_KIND_HI, KIND_IPV4);
		send_frame();
		fill_random(14);
		put16(POS_KIND_HI, KIND_ARP);
		send_frame();
	endtask

	// Long enough that the byte counter saturates and must not wrap into the header.
	task automatic test_counter_saturation();
		make_ipv4(2100, 4'd5, PROTO_UDP, cfg_local, 8'h00);
		send_frame();
		make_ipv4(2060, 4'd5, PROTO_ICMP, cfg_local, ICMP_ECHO_REPLY);
		send_frame();
	endtask

	task automatic test_address_registers();
		wait_idle();
		write_reg(REG_LOCAL, '0);
		write_reg(REG_GATEWAY, '1);
		make_arp(42, ARP_REPLY, cfg_gateway, cfg_local, 48'hdead_0000_beef);
		send_frame();
		make_ipv4(40, 4'd5, PROTO_UDP, cfg_local, 8'h00);
		send_frame();
		wait_idle();
		write_reg(REG_SPARE_A, '1);
		write_reg(REG_SPARE_B, $urandom);
		make_ipv4(40, 4'd5, PROTO_UDP, cfg_local, 8'h00);
		send_frame();
		wait_idle();
		write_reg(REG_LOCAL, '1);
		write_reg(REG_GATEWAY, '0);
		make_arp(44, ARP_REPLY, cfg_gateway, cfg_local, 48'h0123_4567_89ab);
		send_frame();
		make_ipv4(42, 4'd5, PROTO_ICMP, cfg_local, ICMP_ECHO_REPLY);
		send_frame();
		make_ipv4(40, 4'd5, PROTO_UDP, 32'h0a00_0001, 8'h00);
		send_frame();
		wait_idle();
		write_reg(REG_LOCAL, $urandom);
		write_reg(REG_GATEWAY, $urandom);
	endtask

	// The result side holds off while frames keep coming, so the block backs up.
	task automatic test_output_backpressure();
		hold_len = 300;
		repeat (20) begin
			make_random_frame();
			send_frame();
		end
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int frames;
		int bytes;
		frames = 0;
		bytes  = 0;
		while (bytes < 400 || frames < 48) begin
			if (frames % 16 == 15)
				random_config();
			make_random_frame();
			bytes += pkt.size();
			send_frame();
			frames++;
		end
		wait_idle();
	endtask

	task automatic test_full_rate();
		idle_on = 1'b0;
		repeat (12) begin
			make_random_frame();
			send_frame();
		end
		wait_idle();
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		frame_byte  = '0;
		last_byte   = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_LOCAL;
		cfg_data    = '0;
		cfg_local   = LOCAL_RESET;
		cfg_gateway = GATEWAY_RESET;
		gw_mac      = '0;
		gw_known    = 1'b0;
		fail_count  = 0;
		hold_len    = 0;
		cycle_count = 0;
		idle_on     = 1'b1;
		clear_frame();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_arp_replies();
		test_ipv4_traffic();
		test_counter_saturation();
		test_address_registers();
		test_output_backpressure();
		test_random_traffic();
		test_full_rate();

		if (fail_count == 0 && verdict_q.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
